/* rtl/tph_pkg.sv */
// Shared types, sizes and the ordering function for the timer priority heap.
// Depends on nothing; imported by timer_priority_heap, its checker and its testbench.
`timescale 1ns / 1ps
package tph_pkg;

  localparam int CAPACITY = 64;
  localparam int TAG_BITS = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DL_W     = 52;
  localparam int USEC_W   = 20;
  localparam int SEQ_W    = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] deadline_sec;
    logic [19:0] deadline_usec;
    logic        background;
    logic [15:0] event_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] popped_tag;
    logic [31:0] popped_sec;
    logic [19:0] popped_usec;
    logic        popped_background;
    logic [6:0]  timer_count;
    logic [6:0]  foreground_count;
    logic [31:0] next_sec;
    logic [19:0] next_usec;
  } rsp_t;

  typedef struct packed {
    logic [DL_W-1:0]     deadline;
    logic [SEQ_W-1:0]    seq;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  function automatic logic earlier(input entry_t a, input entry_t b);
    if (a.deadline != b.deadline) begin
      return a.deadline < b.deadline;
    end
    return a.seq < b.seq;
  endfunction

endpackage

/* rtl/timer_priority_heap.sv */
// Timer priority heap: a binary min-heap of pending timers held in one RAM.
// Depends on tph_pkg for the transfer structs, entry layout and ordering.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) carries one
// request per transfer: a push of a timer or a pop of the earliest timer.
// The output channel (out_valid_o, out_stall_i, out_data_o) returns exactly
// one result per request: status, the popped timer, the counts and the
// earliest remaining deadline.
// One request is worked at a time. The heap lives in a 64-entry RAM with two
// read ports and one write port, with registered reads. Each level of sift
// up or sift down is a read, then a compare and write back. A push sifts up
// from the new last slot; a pop takes the root, moves the last entry there and
// sifts it down; a rejected request (a push when full, a pop when empty) goes
// straight to the result. The next request is taken as soon as the current
// one has placed its result in the output register; a stalled result holds,
// and a finished request waits for the output register to free up.
// Reset empties the heap (counts and sequence counter to zero); the RAM is
// not cleared, since only entries below the count are ever used.
`timescale 1ns / 1ps
module timer_priority_heap
  import tph_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_DN_GET = 8'b0000_1000,
    S_DN_RD  = 8'b0001_0000,
    S_DN_CMP = 8'b0010_0000,
    S_RT_RD  = 8'b0100_0000,
    S_RT_OUT = 8'b1000_0000
  } state_e;

  entry_t mem [CAPACITY];

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  fg_q, fg_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [IDX_W-1:0]  at_q, at_d;
  entry_t            cur_q, cur_d;
  entry_t            pop_q, pop_d;
  logic              popped_q, popped_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              re_a, re_b, we;
  logic [IDX_W-1:0]  raddr_a, raddr_b, waddr;
  entry_t            wdata, rd_a_q, rd_b_q;

  logic              accept, out_free, fg_new;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W:0]    left, right;
  logic              left_ok, right_ok, take_left, take_right;
  entry_t            best_l;
  logic [SEQ_W-1:0]  seq_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign fg_new   = !in_data_i.background;
  assign seq_next = seq_q + SEQ_W'(2);
  assign parent   = (at_q - IDX_W'(1)) >> 1;
  assign left     = {at_q, 1'b1};
  assign right    = left + (IDX_W + 1)'(1);
  assign left_ok  = (CNT_W)'(left) < count_q && left < (IDX_W + 1)'(CAPACITY);
  assign right_ok = (CNT_W)'(right) < count_q && right < (IDX_W + 1)'(CAPACITY);
  assign take_left  = left_ok && earlier(rd_a_q, cur_q);
  assign best_l     = take_left ? rd_a_q : cur_q;
  assign take_right = right_ok && earlier(rd_b_q, best_l);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_q <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_q <= mem[raddr_b];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    fg_d        = fg_q;
    seq_d       = seq_q;
    at_d        = at_q;
    cur_d       = cur_q;
    pop_d       = pop_q;
    popped_d    = popped_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    re_a        = 1'b0;
    re_b        = 1'b0;
    we          = 1'b0;
    raddr_a     = '0;
    raddr_b     = '0;
    waddr       = at_q;
    wdata       = cur_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          pop_d    = '0;
          popped_d = 1'b0;
          if (in_data_i.req_type == REQ_PUSH) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_RT_RD;
            end else begin
              seq_d          = seq_next;
              cur_d.deadline = {in_data_i.deadline_sec, in_data_i.deadline_usec};
              cur_d.seq      = seq_next + SEQ_W'(fg_new);
              cur_d.tag      = in_data_i.event_tag[TAG_BITS-1:0];
              at_d           = count_q[IDX_W-1:0];
              count_d        = count_q + CNT_W'(1);
              fg_d           = fg_q + CNT_W'(fg_new);
              state_d        = S_UP_RD;
            end
          end else if (count_q == '0) begin
            status_d = ST_EMPTY;
            state_d  = S_RT_RD;
          end else begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            raddr_a = '0;
            raddr_b = IDX_W'(count_q - CNT_W'(1));
            count_d = count_q - CNT_W'(1);
            state_d = S_DN_GET;
          end
        end
      end
      S_UP_RD: begin
        if (at_q == '0) begin
          we      = 1'b1;
          state_d = S_RT_RD;
        end else begin
          re_a    = 1'b1;
          raddr_a = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (earlier(cur_q, rd_a_q)) begin
          wdata   = rd_a_q;
          at_d    = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_RT_RD;
        end
      end
      S_DN_GET: begin
        pop_d    = rd_a_q;
        popped_d = 1'b1;
        fg_d     = fg_q - CNT_W'(rd_a_q.seq[0]);
        cur_d    = rd_b_q;
        at_d     = '0;
        if (count_q == '0) begin
          state_d = S_RT_RD;
        end else begin
          state_d = S_DN_RD;
        end
      end
      S_DN_RD: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = left[IDX_W-1:0];
        raddr_b = right[IDX_W-1:0];
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (take_right) begin
          wdata   = rd_b_q;
          at_d    = right[IDX_W-1:0];
          state_d = S_DN_RD;
        end else if (take_left) begin
          wdata   = rd_a_q;
          at_d    = left[IDX_W-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_RT_RD;
        end
      end
      S_RT_RD: begin
        re_a    = 1'b1;
        raddr_a = '0;
        state_d = S_RT_OUT;
      end
      S_RT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = status_q;
          if (popped_q) begin
            out_d.popped_tag        = 16'(pop_q.tag);
            out_d.popped_sec        = pop_q.deadline[DL_W-1:USEC_W];
            out_d.popped_usec       = pop_q.deadline[USEC_W-1:0];
            out_d.popped_background = !pop_q.seq[0];
          end
          out_d.timer_count      = 7'(count_q);
          out_d.foreground_count = 7'(fg_q);
          if (count_q != '0) begin
            out_d.next_sec  = rd_a_q.deadline[DL_W-1:USEC_W];
            out_d.next_usec = rd_a_q.deadline[USEC_W-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      fg_q        <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fg_q        <= fg_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q     <= at_d;
    cur_q    <= cur_d;
    pop_q    <= pop_d;
    popped_q <= popped_d;
    out_q    <= out_d;
  end

endmodule

/* verif/timer_priority_heap_checker.sv */
// Result checker for the timer priority heap: watches both channels, keeps its own heap.
// Depends on tph_pkg for the request and result structs and status codes.
`timescale 1ns / 1ps
module timer_priority_heap_checker
  import tph_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  rsp_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   result_count_o
);

  logic [51:0] hp_dl[CAPACITY];
  logic [31:0] hp_seq[CAPACITY];
  logic [15:0] hp_tag[CAPACITY];
  int          hp_count;
  int          hp_fg;
  logic [31:0] hp_seq_ctr;
  rsp_t        results_due[$];

  assign pending_o = results_due.size();

  function automatic bit hp_before(int a, int b);
    if (hp_dl[a] != hp_dl[b]) return hp_dl[a] < hp_dl[b];
    return hp_seq[a] < hp_seq[b];
  endfunction

  function automatic void hp_swap(int a, int b);
    logic [51:0] d;
    logic [31:0] s;
    logic [15:0] t;
    d = hp_dl[a]; s = hp_seq[a]; t = hp_tag[a];
    hp_dl[a] = hp_dl[b]; hp_seq[a] = hp_seq[b]; hp_tag[a] = hp_tag[b];
    hp_dl[b] = d; hp_seq[b] = s; hp_tag[b] = t;
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int at;
    int up;
    int best;
    logic fg;
    o = '0;
    if (r.req_type == REQ_PUSH) begin
      if (hp_count >= CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        at = hp_count;
        fg = ~r.background;
        hp_dl[at] = {r.deadline_sec, r.deadline_usec};
        hp_seq_ctr = hp_seq_ctr + 32'd2;
        hp_seq[at] = hp_seq_ctr + 32'(fg);
        hp_tag[at] = r.event_tag;
        hp_count++;
        hp_fg += int'(fg);
        while (at != 0) begin
          up = (at - 1) / 2;
          if (!hp_before(at, up)) break;
          hp_swap(at, up);
          at = up;
        end
      end
    end else begin
      if (hp_count == 0) begin
        o.status = ST_EMPTY;
      end else begin
        fg = hp_seq[0][0];
        o.status = ST_OK;
        o.popped_tag = hp_tag[0];
        o.popped_sec = hp_dl[0][51:20];
        o.popped_usec = hp_dl[0][19:0];
        o.popped_background = ~fg;
        hp_count--;
        hp_fg -= int'(fg);
        if (hp_count != 0) begin
          hp_swap(0, hp_count);
          at = 0;
          forever begin
            best = at;
            if (2 * at + 1 < hp_count && hp_before(2 * at + 1, best)) best = 2 * at + 1;
            if (2 * at + 2 < hp_count && hp_before(2 * at + 2, best)) best = 2 * at + 2;
            if (best == at) break;
            hp_swap(at, best);
            at = best;
          end
        end
      end
    end
    o.timer_count = 7'(hp_count);
    o.foreground_count = 7'(hp_fg);
    if (hp_count != 0) begin
      o.next_sec = hp_dl[0][51:20];
      o.next_usec = hp_dl[0][19:0];
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      hp_count = 0;
      hp_fg = 0;
      hp_seq_ctr = '0;
      fail_count_o <= 0;
      result_count_o <= 0;
      results_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) results_due = {results_due, heap_apply(in_data_i)};
      if (out_valid_i && !out_stall_i) begin
        result_count_o <= result_count_o + 1;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = results_due.pop_front();
          if (out_data_i !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* verif/timer_priority_heap_test.sv */
// Testbench top for the timer priority heap: directed and random push/pop traffic.
// Depends on tph_pkg, timer_priority_heap and timer_priority_heap_checker.
`timescale 1ns / 1ps
module timer_priority_heap_test
  import tph_pkg::*;
();

  localparam int WATCHDOG = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_data_o;
  int   fail_count;
  int   pending;
  int   result_count;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  bit   hold_off;
  int   idle_cycles;
  int   sent;

  timer_priority_heap uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  timer_priority_heap_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always_ff @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_off || ($urandom_range(99) < receiver_stall_pct);
  end

  always_ff @(posedge clk_i) begin
    if (!rst_ni) idle_cycles <= 0;
    else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic req_t rand_req(int pop_pct, int sec_span);
    req_t r;
    r.req_type = ($urandom_range(99) < pop_pct) ? REQ_POP : REQ_PUSH;
    r.deadline_sec = (sec_span == 0) ? $urandom() : $urandom_range(sec_span);
    r.deadline_usec = ($urandom_range(19) == 0) ? 20'($urandom()) : 20'($urandom_range(999999));
    r.background = 1'($urandom_range(1));
    r.event_tag = 16'($urandom());
    return r;
  endfunction

  task automatic send(req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic push_one(logic [31:0] s, logic [19:0] u, logic bg, logic [15:0] t);
    req_t r;
    r = '{REQ_PUSH, s, u, bg, t};
    send(r);
  endtask

  task automatic pop_one();
    req_t r;
    r = '0;
    r.req_type = REQ_POP;
    r.deadline_sec = $urandom();
    r.event_tag = 16'($urandom());
    send(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int mode;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pop_one();
    push_one('1, 20'hFFFFF, 1'b1, 16'hFFFF);
    push_one('0, '0, 1'b0, 16'h0000);
    push_one(32'd5, 20'd999999, 1'b0, 16'h1111);
    push_one(32'd5, 20'd999999, 1'b1, 16'h2222);
    push_one(32'd5, 20'd999999, 1'b0, 16'h3333);
    push_one(32'd5, 20'd0, 1'b1, 16'hAAAA);
    repeat (7) pop_one();
    for (int i = 0; i < CAPACITY + 2; i++) begin
      push_one($urandom_range(3), 20'($urandom_range(9)), 1'($urandom_range(1)), 16'(i));
    end
    repeat (CAPACITY + 2) pop_one();

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      sender_idle_pct = (phase == 1 || phase == 3) ? 83 : (phase == 2 ? 6 : 0);
      receiver_stall_pct = (phase == 2 || phase == 3) ? 83 : (phase == 2 ? 6 : 0);
      if (phase == 2) begin
        sender_idle_pct = 6;
        receiver_stall_pct = 6;
      end
      if (phase == 3) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 83;
      end
      if (phase == 0) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 140; k++) begin
        mode = (k / 40) % 3;
        send(rand_req(mode == 0 ? 25 : (mode == 1 ? 50 : 70), (k % 2) ? 0 : 20));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("run: %0d requests, %0d results, full and empty cases, four idle/stall phases",
             sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
